FILE: src/dboc_pkg.sv
// shared constants, types and codes of the depth band obstacle classifier
`timescale 1ns / 1ps
`default_nettype none

package dboc_pkg;

    // frame size limits
    localparam int MAX_COLS = 2048;
    localparam int MAX_ROWS = 2048;
    localparam int MIN_COLS = 3;
    localparam int MIN_ROWS = 5;

    // field and register widths
    localparam int DEPTH_W = 16;
    localparam int DIM_W   = 12;
    localparam int RATIO_W = 9;
    localparam int CFG_W   = 16;
    localparam int POS_W   = $clog2(MAX_COLS > MAX_ROWS ? MAX_COLS : MAX_ROWS);
    localparam int RW_W    = $clog2(MAX_COLS / 3 + 1);
    localparam int CH_W    = $clog2(MAX_ROWS / 5 + 1);
    localparam int SR_W    = $clog2(2 * MAX_ROWS / 5 + 1);
    localparam int AREA_W  = RW_W + CH_W;
    localparam int LIMIT_W = AREA_W + RATIO_W;

    // accumulators hold a whole frame even after a size change mid-frame
    localparam int CNT_W   = POS_W + RW_W;
    localparam int SUM_W   = CNT_W + DEPTH_W;

    // divider: the mean never exceeds one pixel value
    localparam int QUO_W   = DEPTH_W;
    localparam int STEP_W  = $clog2(QUO_W);

    // constant division by reciprocal multiply
    localparam int          PROD_W     = DIM_W + 1 + 16;
    localparam logic [15:0] RECIP3     = 16'hAAAB;
    localparam int          RECIP3_SH  = 17;
    localparam logic [15:0] RECIP5     = 16'hCCCD;
    localparam int          RECIP5_SH  = 18;

    // item queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // register reset values
    localparam int RST_W     = 640;
    localparam int RST_H     = 480;
    localparam int RST_NEAR  = 1000;
    localparam int RST_RATIO = 77;

    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH     = 2'd0,
        CFG_FRAME_HEIGHT    = 2'd1,
        CFG_NEAR_THRESHOLD  = 2'd2,
        CFG_RATIO_THRESHOLD = 2'd3
    } cfg_index_t;

    // register contents with the frame geometry already worked out
    typedef struct packed {
        logic [POS_W-1:0]   col_last;
        logic [RW_W-1:0]    rw;
        logic [POS_W-1:0]   rw2;
        logic [POS_W-1:0]   rw3;
        logic [POS_W-1:0]   row_last;
        logic [CH_W-1:0]    ch;
        logic [SR_W-1:0]    sr;
        logic [POS_W-1:0]   sr_end;
        logic [DEPTH_W-1:0] near_thr;
        logic [RATIO_W-1:0] ratio;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        col_last: POS_W'(RST_W - 1),
        rw:       RW_W'(RST_W / 3),
        rw2:      POS_W'(2 * (RST_W / 3)),
        rw3:      POS_W'(3 * (RST_W / 3)),
        row_last: POS_W'(RST_H - 1),
        ch:       CH_W'(RST_H / 5),
        sr:       SR_W'(2 * RST_H / 5),
        sr_end:   POS_W'(2 * RST_H / 5 + RST_H / 5),
        near_thr: DEPTH_W'(RST_NEAR),
        ratio:    RATIO_W'(RST_RATIO)
    };

    // per-frame totals handed from front to back
    typedef struct packed {
        logic [CNT_W-1:0] left_near;
        logic [CNT_W-1:0] center_near;
        logic [CNT_W-1:0] right_near;
        logic [SUM_W-1:0] center_sum;
        logic [CNT_W-1:0] center_valid;
    } job_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_AREA,
        B_LIMIT,
        B_DIV,
        B_DONE
    } back_state_t;

endpackage

`default_nettype wire

FILE: src/dboc_if.sv
// pixel and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface dboc_pixel_if;
    logic                        valid;
    logic                        ready;
    logic [dboc_pkg::DEPTH_W-1:0] depth_mm;
    logic                        start_of_frame;

    modport source (output valid, output depth_mm, output start_of_frame, input ready);
    modport sink   (input valid, input depth_mm, input start_of_frame, output ready);
endinterface

interface dboc_result_if;
    logic                        valid;
    logic                        ready;
    logic                        center_blocked;
    logic                        left_free;
    logic                        right_free;
    logic [dboc_pkg::DEPTH_W-1:0] front_distance_mm;

    modport source (
        output valid, output center_blocked, output left_free,
        output right_free, output front_distance_mm, input ready
    );
    modport sink (
        input valid, input center_blocked, input left_free,
        input right_free, input front_distance_mm, output ready
    );
endinterface

`default_nettype wire

FILE: src/dboc_cfg.sv
// configuration registers with derived frame geometry
`timescale 1ns / 1ps
`default_nettype none

module dboc_cfg (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire dboc_pkg::cfg_index_t      cfg_index,
    input  wire logic [dboc_pkg::CFG_W-1:0] cfg_wdata,
    output dboc_pkg::cfg_t                 cfg
);

    dboc_pkg::cfg_t cfg_reg;
    dboc_pkg::cfg_t cfg_next;

    logic [dboc_pkg::DIM_W-1:0]  w_eff;
    logic [dboc_pkg::DIM_W-1:0]  h_eff;
    logic [dboc_pkg::PROD_W-1:0] w_prod;
    logic [dboc_pkg::PROD_W-1:0] h_prod;
    logic [dboc_pkg::PROD_W-1:0] sr_prod;
    logic [dboc_pkg::RW_W-1:0]   rw_new;
    logic [dboc_pkg::CH_W-1:0]   ch_new;
    logic [dboc_pkg::SR_W-1:0]   sr_new;
    logic [dboc_pkg::POS_W-1:0]  rw2_new;

    // saturate written sizes
    always_comb
    begin
        if (cfg_wdata[dboc_pkg::DIM_W-1:0] < dboc_pkg::DIM_W'(dboc_pkg::MIN_COLS))
        begin
            w_eff = dboc_pkg::DIM_W'(dboc_pkg::MIN_COLS);
        end
        else if (cfg_wdata[dboc_pkg::DIM_W-1:0] > dboc_pkg::DIM_W'(dboc_pkg::MAX_COLS))
        begin
            w_eff = dboc_pkg::DIM_W'(dboc_pkg::MAX_COLS);
        end
        else
        begin
            w_eff = cfg_wdata[dboc_pkg::DIM_W-1:0];
        end

        if (cfg_wdata[dboc_pkg::DIM_W-1:0] < dboc_pkg::DIM_W'(dboc_pkg::MIN_ROWS))
        begin
            h_eff = dboc_pkg::DIM_W'(dboc_pkg::MIN_ROWS);
        end
        else if (cfg_wdata[dboc_pkg::DIM_W-1:0] > dboc_pkg::DIM_W'(dboc_pkg::MAX_ROWS))
        begin
            h_eff = dboc_pkg::DIM_W'(dboc_pkg::MAX_ROWS);
        end
        else
        begin
            h_eff = cfg_wdata[dboc_pkg::DIM_W-1:0];
        end
    end

    // region width, band height and band start by reciprocal multiply
    always_comb
    begin
        w_prod  = dboc_pkg::PROD_W'(w_eff) * dboc_pkg::PROD_W'(dboc_pkg::RECIP3);
        h_prod  = dboc_pkg::PROD_W'(h_eff) * dboc_pkg::PROD_W'(dboc_pkg::RECIP5);
        sr_prod = dboc_pkg::PROD_W'({h_eff, 1'b0}) * dboc_pkg::PROD_W'(dboc_pkg::RECIP5);
        rw_new  = w_prod[dboc_pkg::RECIP3_SH +: dboc_pkg::RW_W];
        ch_new  = h_prod[dboc_pkg::RECIP5_SH +: dboc_pkg::CH_W];
        sr_new  = sr_prod[dboc_pkg::RECIP5_SH +: dboc_pkg::SR_W];
        rw2_new = dboc_pkg::POS_W'({rw_new, 1'b0});
    end

    // register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                dboc_pkg::CFG_FRAME_WIDTH:
                begin
                    cfg_next.col_last = dboc_pkg::POS_W'(w_eff - 1'b1);
                    cfg_next.rw       = rw_new;
                    cfg_next.rw2      = rw2_new;
                    cfg_next.rw3      = rw2_new + dboc_pkg::POS_W'(rw_new);
                end
                dboc_pkg::CFG_FRAME_HEIGHT:
                begin
                    cfg_next.row_last = dboc_pkg::POS_W'(h_eff - 1'b1);
                    cfg_next.ch       = ch_new;
                    cfg_next.sr       = sr_new;
                    cfg_next.sr_end   = dboc_pkg::POS_W'(sr_new) + dboc_pkg::POS_W'(ch_new);
                end
                dboc_pkg::CFG_NEAR_THRESHOLD:
                begin
                    cfg_next.near_thr = cfg_wdata[dboc_pkg::DEPTH_W-1:0];
                end
                dboc_pkg::CFG_RATIO_THRESHOLD:
                begin
                    cfg_next.ratio = cfg_wdata[dboc_pkg::RATIO_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= dboc_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: src/dboc_front.sv
// pixel intake: raster position, region classification and accumulators
`timescale 1ns / 1ps
`default_nettype none

module dboc_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    dboc_pixel_if.sink          pixel,
    input  wire dboc_pkg::cfg_t cfg,
    input  wire logic           q_full,
    output logic                push,
    output dboc_pkg::job_t      push_job
);

    logic [dboc_pkg::POS_W-1:0] col_reg;
    logic [dboc_pkg::POS_W-1:0] col_next;
    logic [dboc_pkg::POS_W-1:0] row_reg;
    logic [dboc_pkg::POS_W-1:0] row_next;
    dboc_pkg::job_t             acc_reg;
    dboc_pkg::job_t             acc_next;

    logic [dboc_pkg::POS_W-1:0] col_cur;
    logic [dboc_pkg::POS_W-1:0] row_cur;
    dboc_pkg::job_t             acc_cur;
    dboc_pkg::job_t             acc_new;
    logic                       accept;
    logic                       near;
    logic                       in_band;
    logic                       is_left;
    logic                       is_center;
    logic                       is_right;
    logic                       row_end;
    logic                       frame_end;

    assign pixel.ready = !q_full;
    assign accept      = pixel.valid && pixel.ready;

    // start of frame restarts position and totals before the pixel counts
    always_comb
    begin
        col_cur = pixel.start_of_frame ? '0 : col_reg;
        row_cur = pixel.start_of_frame ? '0 : row_reg;
        acc_cur = pixel.start_of_frame ? '0 : acc_reg;
    end

    // region of the current pixel
    always_comb
    begin
        near      = pixel.depth_mm < cfg.near_thr;
        in_band   = (row_cur >= dboc_pkg::POS_W'(cfg.sr)) && (row_cur < cfg.sr_end);
        is_left   = in_band && (col_cur < dboc_pkg::POS_W'(cfg.rw));
        is_center = in_band && !is_left && (col_cur < cfg.rw2);
        is_right  = in_band && !(col_cur < cfg.rw2) && (col_cur < cfg.rw3);
    end

    // accumulate
    always_comb
    begin
        acc_new = acc_cur;
        acc_new.left_near   = acc_cur.left_near + dboc_pkg::CNT_W'(is_left && near);
        acc_new.center_near = acc_cur.center_near + dboc_pkg::CNT_W'(is_center && near);
        acc_new.right_near  = acc_cur.right_near + dboc_pkg::CNT_W'(is_right && near);
        if (is_center && (pixel.depth_mm != '0))
        begin
            acc_new.center_sum   = acc_cur.center_sum + dboc_pkg::SUM_W'(pixel.depth_mm);
            acc_new.center_valid = acc_cur.center_valid + dboc_pkg::CNT_W'(1);
        end
    end

    // raster advance and frame end
    always_comb
    begin
        row_end   = col_cur >= cfg.col_last;
        frame_end = row_end && (row_cur >= cfg.row_last);
        col_next  = row_end ? '0 : col_cur + dboc_pkg::POS_W'(1);
        if (!row_end)
        begin
            row_next = row_cur;
        end
        else if (frame_end)
        begin
            row_next = '0;
        end
        else
        begin
            row_next = row_cur + dboc_pkg::POS_W'(1);
        end
        acc_next = frame_end ? '0 : acc_new;
        push     = accept && frame_end;
        push_job = acc_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            acc_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            acc_reg <= acc_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/dboc_fifo.sv
// short queue of frame totals between front and back
`timescale 1ns / 1ps
`default_nettype none

module dboc_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire dboc_pkg::job_t wdata,
    input  wire logic           pop,
    output dboc_pkg::job_t      rdata,
    output logic                full,
    output logic                empty
);

    dboc_pkg::job_t               mem_reg [dboc_pkg::Q_DEPTH];
    logic [dboc_pkg::Q_PTR_W-1:0] wr_ptr_reg;
    logic [dboc_pkg::Q_PTR_W-1:0] rd_ptr_reg;
    logic [dboc_pkg::Q_CNT_W-1:0] cnt_reg;
    logic [dboc_pkg::Q_CNT_W-1:0] cnt_next;

    assign full  = cnt_reg == dboc_pkg::Q_CNT_W'(dboc_pkg::Q_DEPTH);
    assign empty = cnt_reg == '0;
    assign rdata = mem_reg[rd_ptr_reg];

    // fill level
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + dboc_pkg::Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - dboc_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + dboc_pkg::Q_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + dboc_pkg::Q_PTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("frame totals pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("frame totals popped from an empty queue");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= dboc_pkg::Q_CNT_W'(dboc_pkg::Q_DEPTH))
        else $error("queue level beyond depth");

endmodule

`default_nettype wire

FILE: src/dboc_back.sv
// frame result: threshold compare, iterative mean divider and output register
`timescale 1ns / 1ps
`default_nettype none

module dboc_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire dboc_pkg::cfg_t cfg,
    input  wire logic           q_empty,
    input  wire dboc_pkg::job_t q_data,
    output logic                pop,
    dboc_result_if.source       result
);

    dboc_pkg::back_state_t        state_reg;
    dboc_pkg::back_state_t        state_next;
    dboc_pkg::job_t               job_reg;
    dboc_pkg::job_t               job_next;
    logic [dboc_pkg::AREA_W-1:0]  area_reg;
    logic [dboc_pkg::AREA_W-1:0]  area_next;
    logic [dboc_pkg::LIMIT_W-1:0] limit_reg;
    logic [dboc_pkg::LIMIT_W-1:0] limit_next;
    logic [dboc_pkg::SUM_W-1:0]   rem_reg;
    logic [dboc_pkg::SUM_W-1:0]   rem_next;
    logic [dboc_pkg::QUO_W-1:0]   quo_reg;
    logic [dboc_pkg::QUO_W-1:0]   quo_next;
    logic [dboc_pkg::STEP_W-1:0]  step_reg;
    logic [dboc_pkg::STEP_W-1:0]  step_next;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         blocked_reg;
    logic                         blocked_next;
    logic                         lclear_reg;
    logic                         lclear_next;
    logic                         rclear_reg;
    logic                         rclear_next;
    logic [dboc_pkg::DEPTH_W-1:0] dist_reg;
    logic [dboc_pkg::DEPTH_W-1:0] dist_next;

    logic [dboc_pkg::SUM_W-1:0]   div_shift;
    logic [dboc_pkg::SUM_W:0]     diff;
    logic [dboc_pkg::LIMIT_W:0]   limit_ext;

    // one restoring step per cycle
    always_comb
    begin
        div_shift = dboc_pkg::SUM_W'(job_reg.center_valid) << step_reg;
        diff      = {1'b0, rem_reg} - {1'b0, div_shift};
        limit_ext = {1'b0, limit_reg};
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        area_next      = area_reg;
        limit_next     = limit_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !result.ready;
        blocked_next   = blocked_reg;
        lclear_next    = lclear_reg;
        rclear_next    = rclear_reg;
        dist_next      = dist_reg;
        pop            = 1'b0;

        case (state_reg)
            dboc_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    job_next   = q_data;
                    state_next = dboc_pkg::B_AREA;
                end
            end
            dboc_pkg::B_AREA:
            begin
                area_next  = dboc_pkg::AREA_W'(cfg.rw) * dboc_pkg::AREA_W'(cfg.ch);
                state_next = dboc_pkg::B_LIMIT;
            end
            dboc_pkg::B_LIMIT:
            begin
                limit_next = dboc_pkg::LIMIT_W'(cfg.ratio) * dboc_pkg::LIMIT_W'(area_reg);
                rem_next   = job_reg.center_sum;
                quo_next   = '0;
                step_next  = dboc_pkg::STEP_W'(dboc_pkg::QUO_W - 1);
                state_next = dboc_pkg::B_DIV;
            end
            dboc_pkg::B_DIV:
            begin
                if (!diff[dboc_pkg::SUM_W])
                begin
                    rem_next = diff[dboc_pkg::SUM_W-1:0];
                    quo_next = quo_reg | (dboc_pkg::QUO_W'(1) << step_reg);
                end
                if (step_reg == '0)
                begin
                    state_next = dboc_pkg::B_DONE;
                end
                else
                begin
                    step_next = step_reg - dboc_pkg::STEP_W'(1);
                end
            end
            dboc_pkg::B_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    blocked_next   = {job_reg.center_near, 8'b0} > limit_ext;
                    lclear_next    = !({job_reg.left_near, 8'b0} > limit_ext);
                    rclear_next    = !({job_reg.right_near, 8'b0} > limit_ext);
                    dist_next      = (job_reg.center_valid == '0) ? '0 : quo_reg;
                    state_next     = dboc_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = dboc_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dboc_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        job_reg     <= job_next;
        area_reg    <= area_next;
        limit_reg   <= limit_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        step_reg    <= step_next;
        blocked_reg <= blocked_next;
        lclear_reg  <= lclear_next;
        rclear_reg  <= rclear_next;
        dist_reg    <= dist_next;
    end

    assign result.valid             = out_valid_reg;
    assign result.center_blocked    = blocked_reg;
    assign result.left_free         = lclear_reg;
    assign result.right_free        = rclear_reg;
    assign result.front_distance_mm = dist_reg;

endmodule

`default_nettype wire

FILE: src/depth_band_obstacle_classifier_core.sv
// top level of the depth band obstacle classifier
//
// pixel channel: one 16-bit depth item per accepted handshake, raster order;
// start_of_frame restarts position and totals at that pixel.
// result channel: one item per frame, given after the last pixel of the frame
// (left/center/right near-pixel flags and the mean nonzero center depth).
// configuration: cfg_we writes cfg_wdata to register cfg_index;
// sizes are saturated and the band geometry is worked out on the write.
// throughput: one pixel per cycle while the totals queue is not full. the back
// part runs a 16-step restoring divider for each frame and takes the next
// frame's totals only once it is done with the last one. frame totals wait
// in a two-entry queue, so the next frame streams in meanwhile;
// pixel ready drops only when that queue is full (very short frames).
// a stalled receiver holds the result register; the back part waits, the
// queue fills, and then pixel ready drops.
// reset: position and totals clear, registers take their reset values
// (640 x 480, near 1000 mm, ratio 77/256), no result pending.
`timescale 1ns / 1ps
`default_nettype none

module depth_band_obstacle_classifier_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    dboc_pixel_if.sink                      pixel,
    dboc_result_if.source                   result,
    input  wire logic                       cfg_we,
    input  wire dboc_pkg::cfg_index_t       cfg_index,
    input  wire logic [dboc_pkg::CFG_W-1:0] cfg_wdata
);

    dboc_pkg::cfg_t cfg;
    dboc_pkg::job_t push_job;
    dboc_pkg::job_t q_data;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;

    // registers
    dboc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // pixel intake and accumulation
    dboc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel    (pixel),
        .cfg      (cfg),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    // frame totals queue
    dboc_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_job),
        .pop   (pop),
        .rdata (q_data),
        .full  (q_full),
        .empty (q_empty)
    );

    // result computation
    dboc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_empty (q_empty),
        .q_data  (q_data),
        .pop     (pop),
        .result  (result)
    );

endmodule

`default_nettype wire

FILE: dv/dboc_frame_checker.sv
// frame verdict checker: watches pixel, result and register traffic, predicts and compares
`timescale 1ns / 1ps

module dboc_frame_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    dboc_pixel_if                           pixel,
    dboc_result_if                          result,
    input  wire logic                       cfg_we,
    input  wire dboc_pkg::cfg_index_t       cfg_index,
    input  wire logic [dboc_pkg::CFG_W-1:0] cfg_wdata,
    output int                              errors,
    output int                              pending,
    output int                              verdicts_seen
);

    typedef struct packed {
        logic                         center_blocked;
        logic                         left_free;
        logic                         right_free;
        logic [dboc_pkg::DEPTH_W-1:0] front_distance_mm;
    } verdict_t;

    // verdicts owed by the block, oldest first
    verdict_t verdict_q[$];

    // shadow registers
    logic [dboc_pkg::DIM_W-1:0]   width_reg;
    logic [dboc_pkg::DIM_W-1:0]   height_reg;
    logic [dboc_pkg::DEPTH_W-1:0] near_thr;
    logic [dboc_pkg::RATIO_W-1:0] ratio_q8;

    // scan position and band totals
    int unsigned       col_pos;
    int unsigned       row_pos;
    int unsigned       left_near;
    int unsigned       center_near;
    int unsigned       right_near;
    int unsigned       center_valid;
    longint unsigned   center_sum;

    function automatic int unsigned saturate(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        errors = errors + 1;
    endtask

    task automatic clear_totals();
        left_near    = 0;
        center_near  = 0;
        right_near   = 0;
        center_valid = 0;
        center_sum   = 0;
    endtask

    task automatic write_register(input dboc_pkg::cfg_index_t idx,
                                  input logic [dboc_pkg::CFG_W-1:0] data);
        case (idx)
            dboc_pkg::CFG_FRAME_WIDTH:     width_reg  = data[dboc_pkg::DIM_W-1:0];
            dboc_pkg::CFG_FRAME_HEIGHT:    height_reg = data[dboc_pkg::DIM_W-1:0];
            dboc_pkg::CFG_NEAR_THRESHOLD:  near_thr   = data[dboc_pkg::DEPTH_W-1:0];
            dboc_pkg::CFG_RATIO_THRESHOLD: ratio_q8   = data[dboc_pkg::RATIO_W-1:0];
            default: ;
        endcase
    endtask

    // one pixel item: update totals, owe a verdict at the last pixel of a frame
    task automatic take_pixel(input logic [dboc_pkg::DEPTH_W-1:0] depth, input logic sof);
        int unsigned     w;
        int unsigned     h;
        int unsigned     rw;
        int unsigned     ch;
        int unsigned     sr;
        logic            near;
        longint unsigned lim;
        verdict_t        v;
        w  = saturate(width_reg, dboc_pkg::MIN_COLS, dboc_pkg::MAX_COLS);
        h  = saturate(height_reg, dboc_pkg::MIN_ROWS, dboc_pkg::MAX_ROWS);
        rw = w / 3;
        ch = h / 5;
        sr = (2 * h) / 5;

        if (sof)
        begin
            col_pos = 0;
            row_pos = 0;
            clear_totals();
        end

        // region tally inside the middle band
        near = depth < near_thr;
        if (row_pos >= sr && row_pos < sr + ch)
        begin
            if (col_pos < rw)
            begin
                if (near)
                    left_near++;
            end
            else if (col_pos < 2 * rw)
            begin
                if (near)
                    center_near++;
                if (depth != 0)
                begin
                    center_sum += depth;
                    center_valid++;
                end
            end
            else if (col_pos < 3 * rw)
            begin
                if (near)
                    right_near++;
            end
        end

        // advance position, close the frame at its last pixel
        if (col_pos < w - 1)
        begin
            col_pos++;
        end
        else
        begin
            col_pos = 0;
            if (row_pos < h - 1)
            begin
                row_pos++;
            end
            else
            begin
                lim = 64'(ratio_q8) * 64'(rw) * 64'(ch);
                v.center_blocked = (64'(center_near) << 8) > lim;
                v.left_free      = !((64'(left_near) << 8) > lim);
                v.right_free     = !((64'(right_near) << 8) > lim);
                v.front_distance_mm = (center_valid == 0) ? '0 :
                                      dboc_pkg::DEPTH_W'(center_sum / center_valid);
                verdict_q.push_back(v);
                row_pos = 0;
                clear_totals();
            end
        end
    endtask

    // one result item against the oldest owed verdict
    task automatic check_verdict();
        verdict_t want;
        if (verdict_q.size() == 0)
        begin
            report("result with no frame pending", result.front_distance_mm, 0);
        end
        else
        begin
            want = verdict_q.pop_front();
            if (result.center_blocked !== want.center_blocked)
                report("center_blocked", result.center_blocked, want.center_blocked);
            if (result.left_free !== want.left_free)
                report("left_free", result.left_free, want.left_free);
            if (result.right_free !== want.right_free)
                report("right_free", result.right_free, want.right_free);
            if (result.front_distance_mm !== want.front_distance_mm)
                report("front_distance_mm", result.front_distance_mm, want.front_distance_mm);
        end
    endtask

    // sample every channel at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = dboc_pkg::DIM_W'(dboc_pkg::RST_W);
            height_reg = dboc_pkg::DIM_W'(dboc_pkg::RST_H);
            near_thr   = dboc_pkg::DEPTH_W'(dboc_pkg::RST_NEAR);
            ratio_q8   = dboc_pkg::RATIO_W'(dboc_pkg::RST_RATIO);
            col_pos    = 0;
            row_pos    = 0;
            clear_totals();
            verdict_q.delete();
            errors        = 0;
            pending       <= 0;
            verdicts_seen <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                check_verdict();
                verdicts_seen <= verdicts_seen + 1;
            end
            // a pixel at a write edge still sees the old registers
            if (pixel.valid && pixel.ready)
                take_pixel(pixel.depth_mm, pixel.start_of_frame);
            if (cfg_we)
                write_register(cfg_index, cfg_wdata);
            pending <= verdict_q.size();
        end
    end

endmodule

FILE: dv/tb_depth_band_obstacle_classifier_core.sv
// testbench top: pixel stimulus, result receiver, register writes and verdict
`timescale 1ns / 1ps

module tb_depth_band_obstacle_classifier_core;

    localparam int IDLE_PCT       = 14;
    localparam int LONG_STALL     = 400;
    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 450;
    localparam int RANDOM_FRAMES  = 6;
    localparam int FRAME_CAP      = 120;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we;
    dboc_pkg::cfg_index_t       cfg_index;
    logic [dboc_pkg::CFG_W-1:0] cfg_wdata;

    dboc_pixel_if  pixel_ch ();
    dboc_result_if result_ch ();

    int   errors;
    int   pending;
    int   verdicts_seen;
    int   pixels_sent = 0;
    int   idle_cycles = 0;
    logic quiet = 1'b0;
    logic stall_req = 1'b0;

    // geometry and threshold as currently programmed
    int cur_w = dboc_pkg::RST_W;
    int cur_h = dboc_pkg::RST_H;
    int cur_thr = dboc_pkg::RST_NEAR;

    depth_band_obstacle_classifier_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    dboc_frame_checker verdict_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixel         (pixel_ch),
        .result        (result_ch),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .errors        (errors),
        .pending       (pending),
        .verdicts_seen (verdicts_seen)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // result receiver with random stalls and one long hold-off
    initial
    begin : receiver
        int   stall_left;
        logic stall_taken;
        stall_left  = 0;
        stall_taken = 1'b0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (stall_req && !stall_taken)
            begin
                stall_left  = LONG_STALL;
                stall_taken = 1'b1;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // watchdog on cycles where no item moves
    always @(posedge clk)
    begin
        if (!rst_n || (pixel_ch.valid && pixel_ch.ready) || (result_ch.valid && result_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int clamp_dim(int v, int lo, int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // sometimes set the unused bits above a register's width
    function automatic logic [dboc_pkg::CFG_W-1:0] with_junk(int value, int width);
        logic [dboc_pkg::CFG_W-1:0] extra;
        extra = ($urandom_range(99) < 20) ? dboc_pkg::CFG_W'($urandom) : '0;
        return dboc_pkg::CFG_W'(value) | dboc_pkg::CFG_W'(extra << width);
    endfunction

    // depth below or above the near threshold, with zero and full-scale pixels mixed in
    function automatic logic [dboc_pkg::DEPTH_W-1:0] pick_depth(int near_pct);
        int r;
        r = $urandom_range(99);
        if (r < 6)
            return '0;
        if (r < 10)
            return '1;
        if ($urandom_range(99) < near_pct)
            return (cur_thr == 0) ? '0 : dboc_pkg::DEPTH_W'($urandom_range(cur_thr - 1, 0));
        return dboc_pkg::DEPTH_W'($urandom_range(65535, cur_thr));
    endfunction

    // offer one pixel item and hold it until accepted
    task automatic send_pixel(input logic [dboc_pkg::DEPTH_W-1:0] depth, input logic sof);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            pixel_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pixel_ch.valid          <= 1'b1;
        pixel_ch.depth_mm       <= depth;
        pixel_ch.start_of_frame <= sof;
        @(posedge clk);
        while (!pixel_ch.ready)
            @(posedge clk);
        pixels_sent++;
    endtask

    // random pixels; noise_pct adds stray start-of-frame marks
    task automatic send_frame(input logic sof, input int count, input int near_pct,
                              input int noise_pct);
        for (int i = 0; i < count; i++)
            send_pixel(pick_depth(near_pct),
                       (i == 0 && sof) || ($urandom_range(99) < noise_pct));
    endtask

    // whole frame with one fixed value per band region
    task automatic send_region_frame(input logic sof, input logic [dboc_pkg::DEPTH_W-1:0] l,
                                     input logic [dboc_pkg::DEPTH_W-1:0] c,
                                     input logic [dboc_pkg::DEPTH_W-1:0] r,
                                     input logic [dboc_pkg::DEPTH_W-1:0] bg);
        int rw;
        int ch;
        int sr;
        logic [dboc_pkg::DEPTH_W-1:0] d;
        rw = cur_w / 3;
        ch = cur_h / 5;
        sr = (2 * cur_h) / 5;
        for (int row = 0; row < cur_h; row++)
            for (int col = 0; col < cur_w; col++)
            begin
                d = bg;
                if (row >= sr && row < sr + ch)
                begin
                    if (col < rw)
                        d = l;
                    else if (col < 2 * rw)
                        d = c;
                    else if (col < 3 * rw)
                        d = r;
                end
                send_pixel(d, sof && row == 0 && col == 0);
            end
    endtask

    // drop valid, wait for every owed verdict, then let the back end drain
    task automatic settle();
        pixel_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input dboc_pkg::cfg_index_t idx,
                             input logic [dboc_pkg::CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    // program the selected registers once the block is idle
    task automatic configure(input logic [3:0] sel, input int w_raw, input int h_raw,
                             input int thr, input int ratio);
        settle();
        if (sel[0])
        begin
            write_reg(dboc_pkg::CFG_FRAME_WIDTH, with_junk(w_raw, dboc_pkg::DIM_W));
            cur_w = clamp_dim(w_raw, dboc_pkg::MIN_COLS, dboc_pkg::MAX_COLS);
        end
        if (sel[1])
        begin
            write_reg(dboc_pkg::CFG_FRAME_HEIGHT, with_junk(h_raw, dboc_pkg::DIM_W));
            cur_h = clamp_dim(h_raw, dboc_pkg::MIN_ROWS, dboc_pkg::MAX_ROWS);
        end
        if (sel[2])
        begin
            write_reg(dboc_pkg::CFG_NEAR_THRESHOLD, with_junk(thr, dboc_pkg::DEPTH_W));
            cur_thr = thr;
        end
        if (sel[3])
            write_reg(dboc_pkg::CFG_RATIO_THRESHOLD, with_junk(ratio, dboc_pkg::RATIO_W));
        cfg_we <= 1'b0;
    endtask

    // stimulus and verdict
    initial
    begin : stimulus
        int rand_start;
        int seen_start;
        int kind;
        int near_pct;
        int count;
        int r;
        int w_raw;
        int h_raw;
        int thr;
        int ratio;

        pixel_ch.valid          <= 1'b0;
        pixel_ch.depth_mm       <= '0;
        pixel_ch.start_of_frame <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= dboc_pkg::CFG_FRAME_WIDTH;
        cfg_wdata <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // smallest frame, reset thresholds: zero pixel near, one below and at the limit
        configure(4'b0011, 3, 5, 0, 0);
        send_region_frame(1'b1, 16'd0, 16'd999, 16'd1000, 16'hFFFF);
        // frame without start mark, no nonzero center pixel
        send_region_frame(1'b0, 16'd1000, 16'd0, 16'hFFFF, 16'd0);
        // frame cut short by a new start mark
        send_frame(1'b1, 7, 50, 0);
        send_region_frame(1'b1, 16'd500, 16'd1500, 16'd0, 16'd1);

        // sizes below minimum, zero threshold and zero ratio: nothing is near
        configure(4'b1111, 2, 0, 0, 0);
        send_region_frame(1'b1, 16'd0, 16'hFFFF, 16'd0, 16'd0);

        // whole band near, fraction exactly at full ratio; columns outside regions
        configure(4'b1111, 5, 4, 65535, 256);
        send_region_frame(1'b1, 16'hFFFE, 16'd1, 16'hFFFE, 16'h1234);
        configure(4'b1000, 0, 0, 0, 255);
        send_region_frame(1'b1, 16'hFFFE, 16'd1, 16'hFFFE, 16'h1234);
        configure(4'b1111, 7, 11, 16'h8000, 511);
        send_region_frame(1'b1, 16'h7FFF, 16'h8000, 16'h7FFF, 16'd0);

        // width shrinks below the current column in mid frame
        configure(4'b0011, 6, 5, 0, 0);
        send_frame(1'b1, 4, 50, 0);
        configure(4'b0001, 3, 0, 0, 0);
        send_frame(1'b0, 20, 50, 0);

        // one wide band row between narrow rows, no idling on either side
        quiet = 1'b1;
        configure(4'b1111, 3, 5, 1000, 77);
        send_frame(1'b1, 6, 30, 0);
        configure(4'b0001, 300, 0, 0, 0);
        send_frame(1'b0, 300, 30, 0);
        configure(4'b0001, 3, 0, 0, 0);
        send_frame(1'b0, 6, 30, 0);
        quiet = 1'b0;

        // receiver holds off while tiny frames keep coming
        configure(4'b1111, 3, 5, 1000, 77);
        stall_req = 1'b1;
        repeat (12) send_frame(1'b1, 15, 50, 0);
        stall_req = 1'b0;

        // random settings and frames, mostly well formed
        rand_start = pixels_sent;
        seen_start = verdicts_seen;
        while (pixels_sent - rand_start < RANDOM_ITEMS ||
               verdicts_seen - seen_start < RANDOM_FRAMES)
        begin
            r = $urandom_range(99);
            w_raw = (r < 75) ? $urandom_range(10, 3) : (r < 85) ? $urandom_range(2, 0) :
                    (r < 97) ? $urandom_range(32, 11) : $urandom_range(4095, 2049);
            r = $urandom_range(99);
            h_raw = (r < 75) ? $urandom_range(12, 5) : (r < 85) ? $urandom_range(4, 0) :
                    (r < 97) ? $urandom_range(30, 13) : $urandom_range(4095, 2049);
            r = $urandom_range(99);
            thr = (r < 45) ? $urandom_range(5000, 200) : (r < 65) ? $urandom_range(65535, 0) :
                  (r < 75) ? 0 : (r < 85) ? 65535 : $urandom_range(16, 1);
            r = $urandom_range(99);
            ratio = (r < 60) ? $urandom_range(256, 0) : (r < 70) ? 0 :
                    (r < 80) ? 256 : $urandom_range(511, 257);
            configure(4'($urandom_range(15, 1)), w_raw, h_raw, thr, ratio);

            repeat ($urandom_range(4, 1))
            begin
                kind     = $urandom_range(99);
                near_pct = $urandom_range(100);
                count    = cur_w * cur_h;
                if (count > FRAME_CAP)
                    count = $urandom_range(60, 1);
                if (kind < 80)
                    send_frame(kind < 60, count, near_pct, 0);
                else
                    send_frame(1'($urandom_range(1)), $urandom_range(count, 1), near_pct, 5);
            end
        end

        // drain and give the verdict
        settle();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
src/dboc_pkg.sv
src/dboc_if.sv
src/dboc_cfg.sv
src/dboc_front.sv
src/dboc_fifo.sv
src/dboc_back.sv
src/depth_band_obstacle_classifier_core.sv
dv/dboc_frame_checker.sv
dv/tb_depth_band_obstacle_classifier_core.sv
